// ===== design/assert_macros.svh =====
// Assertion macros shared by the median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while rst is high.
`define WMF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define WMF_ASSERT_IMP(label, ante, cons, msg) \
  `WMF_ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== design/wmf_pkg.sv =====
// Shared types and constants of the window median filter.
`default_nettype none
package wmf_pkg;
  localparam int PIXEL_W       = 8;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 12;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_INDEX_W   = 1;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_WINDOW    = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef logic [PIXEL_W-1:0] pixel_t;
endpackage
`default_nettype wire

// ===== design/window_median_filter_unit.sv =====
// Top level of the streaming window median filter.
//
//  channel    signals                               direction
//  config     cfg_we, cfg_index, cfg_data           in, write only
//  pixel      pixel_valid/pixel_ready, pixel        in
//  median     median_valid/median_ready,            out
//             median_value, last_of_frame
//
//  Throughput one pixel per clock while pixel_ready is high; a pixel passes the
//  front stage register, the queue, stages a and b and the output register.
//  Line buffer is one RAM read and one RAM write per pixel; pixel_ready drops
//  while the front stage and the four-entry queue together hold four entries.
//  Synchronous reset clears counters and control; config write restarts frame.
//  A stalled output backs up the median pipeline, then the queue, then pixel_ready.
`default_nettype none
`include "assert_macros.svh"
module window_median_filter_unit #(
  parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH,
  parameter int WINDOW    = wmf_pkg::DEF_WINDOW
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [wmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_ready,
  input  wire wmf_pkg::pixel_t                 pixel,
  output logic                                 median_valid,
  input  wire logic                            median_ready,
  output wmf_pkg::pixel_t                      median_value,
  output logic                                 last_of_frame
);
  localparam int QW = WINDOW * WINDOW * wmf_pkg::PIXEL_W + 1;
  localparam logic [wmf_pkg::QUEUE_COUNT_W-1:0] QFULL =
    wmf_pkg::QUEUE_COUNT_W'(wmf_pkg::QUEUE_DEPTH);

  logic                                q_push;
  logic [QW-1:0]                       q_push_data;
  logic                                q_pop;
  logic                                q_head_valid;
  logic [QW-1:0]                       q_head_data;
  logic [wmf_pkg::QUEUE_COUNT_W-1:0]   q_count;

  wmf_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .WINDOW   (WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .q_count    (q_count),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  wmf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head_data),
    .count     (q_count)
  );

  wmf_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head_data    (q_head_data),
    .pop          (q_pop),
    .median_valid (median_valid),
    .median_ready (median_ready),
    .median_value (median_value),
    .last_of_frame(last_of_frame)
  );

  `WMF_ASSERT_IMP(a_queue_no_overflow, q_push && !q_pop, q_count != QFULL, "queue overflow")
  `WMF_ASSERT_IMP(a_queue_no_underflow, q_pop, q_count != '0, "queue underflow")
  `WMF_ASSERT_IMP(a_push_follows_pixel, q_push, $past(pixel_valid && pixel_ready), "stray push")
endmodule
`default_nettype wire

// ===== design/wmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/wmf_front.sv =====
// Front end: config registers, raster counters, line buffer and window gathering.
`default_nettype none
module wmf_front #(
  parameter int MAX_WIDTH = wmf_pkg::DEF_MAX_WIDTH,
  parameter int WINDOW    = wmf_pkg::DEF_WINDOW
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [wmf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [wmf_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                   pixel_valid,
  output logic                                        pixel_ready,
  input  wire wmf_pkg::pixel_t                        pixel,
  input  wire logic [wmf_pkg::QUEUE_COUNT_W-1:0]      q_count,
  output logic                                        push,
  output logic [WINDOW*WINDOW*wmf_pkg::PIXEL_W:0]     push_data
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = wmf_pkg::HEIGHT_REG_W;
  localparam int SR   = WINDOW - 1;
  localparam int AREA = WINDOW * WINDOW;
  localparam int PW   = wmf_pkg::PIXEL_W;
  localparam int QCW  = wmf_pkg::QUEUE_COUNT_W;

  logic [wmf_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [wmf_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [CW-1:0]                    col;
  logic [RW-1:0]                    row;
  logic [CW-1:0]                    col_max;
  logic [RW-1:0]                    row_max;
  logic                             col_last;
  logic                             row_last;
  logic                             accept;

  logic                             s1_valid;
  wmf_pkg::pixel_t                  s1_pixel;
  logic [CW-1:0]                    s1_col;
  logic                             s1_produce;
  logic                             s1_last;

  logic [SR*PW-1:0]                 ram_rdata;
  logic [SR*PW-1:0]                 ram_wdata;
  wmf_pkg::pixel_t                  column [WINDOW];
  wmf_pkg::pixel_t                  window [AREA];
  wmf_pkg::pixel_t                  window_next [AREA];
  logic [QCW:0]                     pending;

  always_comb begin
    if (image_width == '0) begin
      col_max = '0;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      col_max = CW'(MAX_WIDTH - 1);
    end else begin
      col_max = CW'(image_width - 11'd1);
    end
    row_max = (image_height == '0) ? '0 : image_height - 12'd1;
  end

  assign col_last = (col == col_max);
  assign row_last = (row == row_max);
  assign pending  = {1'b0, q_count} + {{QCW{1'b0}}, s1_valid};
  assign pixel_ready = (pending < (QCW + 1)'(wmf_pkg::QUEUE_DEPTH));
  assign accept   = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= wmf_pkg::WIDTH_REG_W'(wmf_pkg::WIDTH_RESET);
      image_height <= wmf_pkg::HEIGHT_REG_W'(wmf_pkg::HEIGHT_RESET);
      col          <= '0;
      row          <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_we) begin
        unique case (cfg_index)
          wmf_pkg::REG_IMAGE_WIDTH: begin
            image_width <= cfg_data[wmf_pkg::WIDTH_REG_W-1:0];
          end
          wmf_pkg::REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[wmf_pkg::HEIGHT_REG_W-1:0];
          end
          default: begin
          end
        endcase
        col <= '0;
        row <= '0;
      end else if (accept) begin
        if (col_last) begin
          col <= '0;
          row <= row_last ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel   <= pixel;
      s1_col     <= col;
      s1_produce <= (32'(row) >= 32'(SR)) && (32'(col) >= 32'(SR));
      s1_last    <= row_last && col_last;
    end
  end

  // line buffer: one word per column, oldest row in the low slice
  wmf_ram #(
    .WIDTH(SR * PW),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(col),
    .rdata(ram_rdata)
  );

  always_comb begin
    for (int k = 0; k < SR; k++) begin
      column[k] = ram_rdata[k*PW +: PW];
    end
    column[SR] = s1_pixel;
    for (int k = 0; k < SR; k++) begin
      ram_wdata[k*PW +: PW] = column[k+1];
    end
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW - 1; c++) begin
        window_next[r*WINDOW + c] = window[r*WINDOW + c + 1];
      end
      window_next[r*WINDOW + WINDOW - 1] = column[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AREA; i++) begin
        window[i] <= '0;
      end
    end else if (s1_valid) begin
      window <= window_next;
    end
  end

  always_comb begin
    push_data[AREA*PW] = s1_last;
    for (int i = 0; i < AREA; i++) begin
      push_data[i*PW +: PW] = window_next[i];
    end
  end

  assign push = s1_valid && s1_produce;
endmodule
`default_nettype wire

// ===== design/wmf_queue.sv =====
// Short FIFO of gathered windows between front and back end.
`default_nettype none
module wmf_queue #(
  parameter int WIDTH = 73
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic [WIDTH-1:0]                  push_data,
  input  wire logic                              pop,
  output logic                                   head_valid,
  output logic [WIDTH-1:0]                       head_data,
  output logic [wmf_pkg::QUEUE_COUNT_W-1:0]      count
);
  localparam int PTW = wmf_pkg::QUEUE_PTR_W;

  logic [WIDTH-1:0] slots [wmf_pkg::QUEUE_DEPTH];
  logic [PTW-1:0]   wr_ptr;
  logic [PTW-1:0]   rd_ptr;

  function automatic logic [PTW-1:0] ptr_inc(input logic [PTW-1:0] p);
    ptr_inc = (p == PTW'(wmf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
endmodule
`default_nettype wire

// ===== design/wmf_back.sv =====
// Back end: rank-based median selection pipeline with output register.
`default_nettype none
module wmf_back #(
  parameter int WINDOW = wmf_pkg::DEF_WINDOW
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 head_valid,
  input  wire logic [WINDOW*WINDOW*wmf_pkg::PIXEL_W:0] head_data,
  output logic                                      pop,
  output logic                                      median_valid,
  input  wire logic                                 median_ready,
  output wmf_pkg::pixel_t                           median_value,
  output logic                                      last_of_frame
);
  localparam int N   = WINDOW * WINDOW;
  localparam int MID = N / 2;
  localparam int RKW = $clog2(N + 1);
  localparam int PW  = wmf_pkg::PIXEL_W;

  logic            en;
  wmf_pkg::pixel_t hv [N];
  logic [N-1:0]    before_c [N];

  logic            a_valid;
  wmf_pkg::pixel_t a_val [N];
  logic [N-1:0]    a_before [N];
  logic            a_last;

  logic [RKW-1:0]  rank [N];
  logic [N-1:0]    sel_c;
  logic            b_valid;
  wmf_pkg::pixel_t b_val [N];
  logic [N-1:0]    b_sel;
  logic            b_last;

  wmf_pkg::pixel_t pick;

  assign en  = !median_valid || median_ready;
  assign pop = en && head_valid;

  // element j sorts ahead of element i; ties broken by position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hv[i] = head_data[i*PW +: PW];
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        before_c[i][j] = (hv[j] < hv[i]) || ((hv[j] == hv[i]) && (j < i));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        rank[i] = rank[i] + RKW'(a_before[i][j]);
      end
      sel_c[i] = (rank[i] == RKW'(MID));
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      if (b_sel[i]) begin
        pick = pick | b_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      median_valid <= 1'b0;
    end else if (en) begin
      a_valid      <= head_valid;
      b_valid      <= a_valid;
      median_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_val         <= hv;
      a_before      <= before_c;
      a_last        <= head_data[N*PW];
      b_val         <= a_val;
      b_sel         <= sel_c;
      b_last        <= a_last;
      median_value  <= pick;
      last_of_frame <= b_last;
    end
  end
endmodule
`default_nettype wire
